@@ rtl/lrc_pkg.sv @@
// shared types, widths and helpers of the line rectangle clipper
package lrc_pkg;

	localparam int COORD_W      = 32;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int MAG_W        = COORD_W;
	localparam int PROD_W       = 2 * MAG_W;
	localparam int QUOT_W       = 35;
	localparam int QUOT_LIM_LOG = 34;
	localparam int RES_W        = QUOT_W + 1;
	localparam int SUM_W        = RES_W + 1;
	localparam int CFG_IDX_W    = 2;
	// operand reg, magnitude reg, product reg, one reg per quotient bit, result reg
	localparam int MD_LAT       = 3 + QUOT_W + 1;

	localparam logic [QUOT_W-1:0] QUOT_LIM = QUOT_W'(1) << QUOT_LIM_LOG;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN,
		REG_X_MAX,
		REG_Y_MIN,
		REG_Y_MAX
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [RES_W-1:0]   quot_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_t;

	typedef struct packed {
		logic   visible;
		coord_t clipped_start_x;
		coord_t clipped_start_y;
		coord_t clipped_end_x;
		coord_t clipped_end_y;
	} clip_t;

	// segment in the major-axis frame, u major, v minor
	typedef struct packed {
		logic   vis;
		logic   swap;
		logic   rev;
		coord_t u1;
		coord_t v1;
		coord_t u2;
		coord_t v2;
		coord_t umin;
		coord_t umax;
		coord_t vmin;
		coord_t vmax;
		diff_t  du;
		diff_t  dv;
	} frame_t;

	function automatic logic [MAG_W-1:0] mag(input diff_t v);
		diff_t n;
		n = -v;
		return v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	function automatic coord_t sat32(input sum_t v);
		if (&v[SUM_W-1:COORD_W-1] || ~|v[SUM_W-1:COORD_W-1])
			return v[COORD_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

endpackage

@@ rtl/lrc_seg_if.sv @@
// segment input channel
interface lrc_seg_if;
	logic          valid;
	logic          ready;
	lrc_pkg::seg_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/lrc_clip_if.sv @@
// clipped segment output channel
interface lrc_clip_if;
	logic           valid;
	logic           ready;
	lrc_pkg::clip_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/lrc_cfg_if.sv @@
// window register write channel
interface lrc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lrc_pkg::CFG_IDX_W-1:0]    index;
	lrc_pkg::coord_t                  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/lrc_muldiv.sv @@
// pipelined signed a*b/c, truncating toward zero, quotient magnitude clamped to 2^34
module lrc_muldiv (
	input  logic           clk,
	input  logic           en,
	input  lrc_pkg::diff_t a,
	input  lrc_pkg::diff_t b,
	input  lrc_pkg::diff_t c,
	output lrc_pkg::quot_t q
);

	lrc_pkg::diff_t a_s0, b_s0, c_s0;

	logic [lrc_pkg::MAG_W-1:0] ma_s1, mb_s1, mc_s1;
	logic                      neg_s1, cz_s1;

	logic [lrc_pkg::PROD_W-1:0] p_s2;
	logic [lrc_pkg::MAG_W-1:0]  mc_s2;
	logic                       neg_s2, cz_s2;

	logic [lrc_pkg::MAG_W-1:0]  rem_s [lrc_pkg::QUOT_W];
	logic [lrc_pkg::MAG_W-1:0]  dvs_s [lrc_pkg::QUOT_W];
	logic [lrc_pkg::QUOT_W-1:0] quo_s [lrc_pkg::QUOT_W];
	logic [lrc_pkg::QUOT_W-1:0] lo_s  [lrc_pkg::QUOT_W];
	logic                       neg_s [lrc_pkg::QUOT_W];
	logic                       cz_s  [lrc_pkg::QUOT_W];
	logic                       ovf_s [lrc_pkg::QUOT_W];

	lrc_pkg::quot_t q_out_s;

	logic [lrc_pkg::MAG_W-1:0] hi_init;
	logic                      ovf_init;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s0   <= a;
			b_s0   <= b;
			c_s0   <= c;
			ma_s1  <= lrc_pkg::mag(a_s0);
			mb_s1  <= lrc_pkg::mag(b_s0);
			mc_s1  <= lrc_pkg::mag(c_s0);
			neg_s1 <= a_s0[lrc_pkg::DIFF_W-1] ^ b_s0[lrc_pkg::DIFF_W-1]
				^ c_s0[lrc_pkg::DIFF_W-1];
			cz_s1  <= (c_s0 == '0);
			p_s2   <= lrc_pkg::PROD_W'(ma_s1) * lrc_pkg::PROD_W'(mb_s1);
			mc_s2  <= mc_s1;
			neg_s2 <= neg_s1;
			cz_s2  <= cz_s1;
		end
	end

	// quotient of 2^35 or more shows up as a high part not below the divisor
	assign hi_init  = lrc_pkg::MAG_W'(p_s2[lrc_pkg::PROD_W-1:lrc_pkg::QUOT_W]);
	assign ovf_init = (hi_init >= mc_s2);

	for (genvar k = 0; k < lrc_pkg::QUOT_W; k++) begin : g_step
		logic [lrc_pkg::MAG_W-1:0]  rin, min_d;
		logic [lrc_pkg::QUOT_W-1:0] qin, lin;
		logic                       nin, zin, oin;
		logic [lrc_pkg::MAG_W:0]    trial, tsub;
		logic                       ge;

		if (k == 0) begin : g_first
			assign rin   = hi_init;
			assign min_d = mc_s2;
			assign qin   = '0;
			assign lin   = p_s2[lrc_pkg::QUOT_W-1:0];
			assign nin   = neg_s2;
			assign zin   = cz_s2;
			assign oin   = ovf_init;
		end else begin : g_next
			assign rin   = rem_s[k-1];
			assign min_d = dvs_s[k-1];
			assign qin   = quo_s[k-1];
			assign lin   = lo_s[k-1];
			assign nin   = neg_s[k-1];
			assign zin   = cz_s[k-1];
			assign oin   = ovf_s[k-1];
		end

		assign trial = {rin, lin[lrc_pkg::QUOT_W-1]};
		assign tsub  = trial - {1'b0, min_d};
		assign ge    = (trial >= {1'b0, min_d});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? tsub[lrc_pkg::MAG_W-1:0] : trial[lrc_pkg::MAG_W-1:0];
				dvs_s[k] <= min_d;
				quo_s[k] <= {qin[lrc_pkg::QUOT_W-2:0], ge};
				lo_s[k]  <= {lin[lrc_pkg::QUOT_W-2:0], 1'b0};
				neg_s[k] <= nin;
				cz_s[k]  <= zin;
				ovf_s[k] <= oin;
			end
		end
	end

	logic [lrc_pkg::QUOT_W-1:0] qmag;
	lrc_pkg::quot_t             qpos;

	always_comb begin
		if (ovf_s[lrc_pkg::QUOT_W-1] || quo_s[lrc_pkg::QUOT_W-1] > lrc_pkg::QUOT_LIM)
			qmag = lrc_pkg::QUOT_LIM;
		else
			qmag = quo_s[lrc_pkg::QUOT_W-1];
		qpos = lrc_pkg::quot_t'({1'b0, qmag});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cz_s[lrc_pkg::QUOT_W-1])
				q_out_s <= '0;
			else if (neg_s[lrc_pkg::QUOT_W-1])
				q_out_s <= -qpos;
			else
				q_out_s <= qpos;
		end
	end

	assign q = q_out_s;

endmodule

@@ rtl/line_rectangle_clipper.sv @@
// top level: segment clipper against a configured rectangle
//
// Clips one segment (signed Q16.16 ends) against the window held in four
// registers written over cfg (index 0..3: x min, x max, y min, y max).
// cfg is always ready; write it only while no segment is in flight.
// seg carries one segment per beat, clip returns one result per beat in
// the same order, with visible low and all coordinates zero when nothing
// of the segment lies inside the window.
// Most of the path from an accepted seg beat to its clip beat is two rows of
// pipelined dividers, 39 stages each, one quotient bit per divide stage;
// the second row needs the clipped first end from the first.
// Throughput is one segment per cycle while clip is ready.
// When clip stalls, the result sits in the output register and one more
// lands in a skid register; seg.ready then drops and the whole pipeline
// holds, nothing is lost or repeated. seg.ready returns the cycle after
// clip.ready is seen high.
// Reset clears the window to zero and empties the pipeline.
module line_rectangle_clipper (
	input logic      clk,
	input logic      arst_n,
	lrc_cfg_if.sink  cfg,
	lrc_seg_if.sink  seg,
	lrc_clip_if.source clip
);

	localparam int LAST = lrc_pkg::MD_LAT - 1;

	lrc_pkg::coord_t wx_min_q, wx_max_q, wy_min_q, wy_max_q;

	logic adv;

	// window registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_min_q <= '0;
			wx_max_q <= '0;
			wy_min_q <= '0;
			wy_max_q <= '0;
		end else if (cfg.valid) begin
			case (lrc_pkg::cfg_reg_t'(cfg.index))
				lrc_pkg::REG_X_MIN: wx_min_q <= cfg.data;
				lrc_pkg::REG_X_MAX: wx_max_q <= cfg.data;
				lrc_pkg::REG_Y_MIN: wy_min_q <= cfg.data;
				lrc_pkg::REG_Y_MAX: wy_max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage 1: input beat
	lrc_pkg::seg_t seg_s1;
	logic          v_s1;

	assign seg.ready = adv;

	// stage 2: deltas and trivial reject
	lrc_pkg::seg_t  seg_s2;
	lrc_pkg::diff_t dx_s2, dy_s2;
	logic           vis_s2, v_s2;
	lrc_pkg::diff_t dx_c, dy_c;
	logic           rej_c;

	always_comb begin
		dx_c  = lrc_pkg::diff_t'(seg_s1.end_x) - lrc_pkg::diff_t'(seg_s1.start_x);
		dy_c  = lrc_pkg::diff_t'(seg_s1.end_y) - lrc_pkg::diff_t'(seg_s1.start_y);
		rej_c = (seg_s1.start_x < wx_min_q && seg_s1.end_x < wx_min_q)
			|| (seg_s1.start_x > wx_max_q && seg_s1.end_x > wx_max_q)
			|| (seg_s1.start_y < wy_min_q && seg_s1.end_y < wy_min_q)
			|| (seg_s1.start_y > wy_max_q && seg_s1.end_y > wy_max_q)
			|| (dx_c == '0 && dy_c == '0);
	end

	// stage 3: pick the major axis
	lrc_pkg::frame_t fr_s3, fr_c3;
	logic            v_s3;

	always_comb begin
		fr_c3      = '0;
		fr_c3.vis  = vis_s2;
		fr_c3.swap = lrc_pkg::mag(dx_s2) < lrc_pkg::mag(dy_s2);
		if (fr_c3.swap) begin
			fr_c3.u1   = seg_s2.start_y;
			fr_c3.v1   = seg_s2.start_x;
			fr_c3.u2   = seg_s2.end_y;
			fr_c3.v2   = seg_s2.end_x;
			fr_c3.umin = wy_min_q;
			fr_c3.umax = wy_max_q;
			fr_c3.vmin = wx_min_q;
			fr_c3.vmax = wx_max_q;
			fr_c3.du   = dy_s2;
			fr_c3.dv   = dx_s2;
		end else begin
			fr_c3.u1   = seg_s2.start_x;
			fr_c3.v1   = seg_s2.start_y;
			fr_c3.u2   = seg_s2.end_x;
			fr_c3.v2   = seg_s2.end_y;
			fr_c3.umin = wx_min_q;
			fr_c3.umax = wx_max_q;
			fr_c3.vmin = wy_min_q;
			fr_c3.vmax = wy_max_q;
			fr_c3.du   = dx_s2;
			fr_c3.dv   = dy_s2;
		end
	end

	// stage 4: order ends so u rises
	lrc_pkg::frame_t fr_s4, fr_c4;
	logic            v_s4;

	always_comb begin
		fr_c4     = fr_s3;
		fr_c4.rev = fr_s3.u2 < fr_s3.u1;
		if (fr_c4.rev) begin
			fr_c4.u1 = fr_s3.u2;
			fr_c4.v1 = fr_s3.v2;
			fr_c4.u2 = fr_s3.u1;
			fr_c4.v2 = fr_s3.v1;
			fr_c4.du = -fr_s3.du;
			fr_c4.dv = -fr_s3.dv;
		end
	end

	// first divider row: entry v, reach test, entry u on the v edge
	lrc_pkg::diff_t  a1_b, a2_b, a3_b;
	lrc_pkg::coord_t vlim_a;
	lrc_pkg::quot_t  qa1, qa2, qa3;

	always_comb begin
		vlim_a = (!fr_s4.dv[lrc_pkg::DIFF_W-1] && fr_s4.dv != '0) ? fr_s4.vmin : fr_s4.vmax;
		a1_b   = lrc_pkg::diff_t'(fr_s4.umin) - lrc_pkg::diff_t'(fr_s4.u2);
		a2_b   = lrc_pkg::diff_t'(fr_s4.umax) - lrc_pkg::diff_t'(fr_s4.u2);
		a3_b   = lrc_pkg::diff_t'(vlim_a) - lrc_pkg::diff_t'(fr_s4.v2);
	end

	lrc_muldiv u_md_a1 (.clk(clk), .en(adv), .a(fr_s4.dv), .b(a1_b), .c(fr_s4.du), .q(qa1));
	lrc_muldiv u_md_a2 (.clk(clk), .en(adv), .a(fr_s4.dv), .b(a2_b), .c(fr_s4.du), .q(qa2));
	lrc_muldiv u_md_a3 (.clk(clk), .en(adv), .a(fr_s4.du), .b(a3_b), .c(fr_s4.dv), .q(qa3));

	lrc_pkg::frame_t cxa_s   [lrc_pkg::MD_LAT];
	logic            cxa_v_s [lrc_pkg::MD_LAT];

	// stage 5: first end onto the u min edge
	lrc_pkg::frame_t fr_s5, fr_c5;
	lrc_pkg::sum_t   reach_s5;
	lrc_pkg::coord_t ucand_s5;
	logic            v_s5;

	always_comb begin
		fr_c5 = cxa_s[LAST];
		if (cxa_s[LAST].u1 < cxa_s[LAST].umin) begin
			fr_c5.u1 = cxa_s[LAST].umin;
			fr_c5.v1 = lrc_pkg::sat32(lrc_pkg::sum_t'(cxa_s[LAST].v2) + lrc_pkg::sum_t'(qa1));
		end
	end

	// stage 6: first end onto the v edge, or reject
	lrc_pkg::frame_t fr_s6, fr_c6;
	logic            v_s6;

	always_comb begin
		fr_c6 = fr_s5;
		if (!fr_s5.dv[lrc_pkg::DIFF_W-1] && fr_s5.dv != '0) begin
			if (fr_s5.v1 > fr_s5.vmax) begin
				fr_c6.vis = 1'b0;
			end else if (fr_s5.v1 < fr_s5.vmin) begin
				if (reach_s5 < lrc_pkg::sum_t'(fr_s5.vmin)) begin
					fr_c6.vis = 1'b0;
				end else begin
					fr_c6.v1 = fr_s5.vmin;
					fr_c6.u1 = ucand_s5;
				end
			end
		end else begin
			if (fr_s5.v1 < fr_s5.vmin) begin
				fr_c6.vis = 1'b0;
			end else if (fr_s5.v1 > fr_s5.vmax) begin
				if (reach_s5 > lrc_pkg::sum_t'(fr_s5.vmax)) begin
					fr_c6.vis = 1'b0;
				end else begin
					fr_c6.v1 = fr_s5.vmax;
					fr_c6.u1 = ucand_s5;
				end
			end
		end
	end

	// second divider row: exit v on the u max edge, exit u on the v edge
	lrc_pkg::diff_t  b1_b, b2_b;
	lrc_pkg::coord_t vlim_b;
	lrc_pkg::quot_t  qb1, qb2;

	always_comb begin
		vlim_b = fr_s6.dv[lrc_pkg::DIFF_W-1] ? fr_s6.vmin : fr_s6.vmax;
		b1_b   = lrc_pkg::diff_t'(fr_s6.umax) - lrc_pkg::diff_t'(fr_s6.u1);
		b2_b   = lrc_pkg::diff_t'(vlim_b) - lrc_pkg::diff_t'(fr_s6.v1);
	end

	lrc_muldiv u_md_b1 (.clk(clk), .en(adv), .a(fr_s6.dv), .b(b1_b), .c(fr_s6.du), .q(qb1));
	lrc_muldiv u_md_b2 (.clk(clk), .en(adv), .a(fr_s6.du), .b(b2_b), .c(fr_s6.dv), .q(qb2));

	lrc_pkg::frame_t cxb_s   [lrc_pkg::MD_LAT];
	logic            cxb_v_s [lrc_pkg::MD_LAT];

	// stage 7: second end onto the u max edge
	lrc_pkg::frame_t fr_s7, fr_c7;
	lrc_pkg::coord_t u2cand_s7;
	logic            v_s7;

	always_comb begin
		fr_c7 = cxb_s[LAST];
		if (cxb_s[LAST].u2 > cxb_s[LAST].umax) begin
			fr_c7.u2 = cxb_s[LAST].umax;
			fr_c7.v2 = lrc_pkg::sat32(lrc_pkg::sum_t'(cxb_s[LAST].v1) + lrc_pkg::sum_t'(qb1));
		end
	end

	// final: second end onto the v edge, back to caller order and axes
	lrc_pkg::frame_t fr_f;
	lrc_pkg::clip_t  res_c;

	always_comb begin
		fr_f = fr_s7;
		if (fr_s7.dv[lrc_pkg::DIFF_W-1]) begin
			if (fr_s7.v2 < fr_s7.vmin) begin
				fr_f.v2 = fr_s7.vmin;
				fr_f.u2 = u2cand_s7;
			end
		end else begin
			if (fr_s7.v2 > fr_s7.vmax) begin
				fr_f.v2 = fr_s7.vmax;
				fr_f.u2 = u2cand_s7;
			end
		end
		if (fr_s7.rev) begin
			fr_f.u1 = fr_f.u2;
			fr_f.v1 = fr_f.v2;
			fr_f.u2 = fr_s7.rev ? (fr_s7.dv[lrc_pkg::DIFF_W-1] ? fr_s7.u1 : fr_s7.u1) : fr_s7.u1;
			fr_f.v2 = fr_s7.v1;
		end
		res_c = '0;
		if (fr_s7.vis) begin
			res_c.visible = 1'b1;
			if (fr_s7.swap) begin
				res_c.clipped_start_x = fr_f.v1;
				res_c.clipped_start_y = fr_f.u1;
				res_c.clipped_end_x   = fr_f.v2;
				res_c.clipped_end_y   = fr_f.u2;
			end else begin
				res_c.clipped_start_x = fr_f.u1;
				res_c.clipped_start_y = fr_f.v1;
				res_c.clipped_end_x   = fr_f.u2;
				res_c.clipped_end_y   = fr_f.v2;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1    <= seg.data;
			seg_s2    <= seg_s1;
			dx_s2     <= dx_c;
			dy_s2     <= dy_c;
			vis_s2    <= !rej_c;
			fr_s3     <= fr_c3;
			fr_s4     <= fr_c4;
			cxa_s[0]  <= fr_s4;
			for (int i = 1; i < lrc_pkg::MD_LAT; i++)
				cxa_s[i] <= cxa_s[i-1];
			fr_s5     <= fr_c5;
			reach_s5  <= lrc_pkg::sum_t'(cxa_s[LAST].v2) + lrc_pkg::sum_t'(qa2);
			ucand_s5  <= lrc_pkg::sat32(lrc_pkg::sum_t'(cxa_s[LAST].u2) + lrc_pkg::sum_t'(qa3));
			fr_s6     <= fr_c6;
			cxb_s[0]  <= fr_s6;
			for (int i = 1; i < lrc_pkg::MD_LAT; i++)
				cxb_s[i] <= cxb_s[i-1];
			fr_s7     <= fr_c7;
			u2cand_s7 <= lrc_pkg::sat32(lrc_pkg::sum_t'(cxb_s[LAST].u1) + lrc_pkg::sum_t'(qb2));
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int i = 0; i < lrc_pkg::MD_LAT; i++) begin
				cxa_v_s[i] <= 1'b0;
				cxb_v_s[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1       <= seg.valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			cxa_v_s[0] <= v_s4;
			for (int i = 1; i < lrc_pkg::MD_LAT; i++)
				cxa_v_s[i] <= cxa_v_s[i-1];
			v_s5       <= cxa_v_s[LAST];
			v_s6       <= v_s5;
			cxb_v_s[0] <= v_s6;
			for (int i = 1; i < lrc_pkg::MD_LAT; i++)
				cxb_v_s[i] <= cxb_v_s[i-1];
			v_s7       <= cxb_v_s[LAST];
		end
	end

	// output register plus skid; the pipeline holds while the skid is full
	lrc_pkg::clip_t out_q, skid_q;
	logic           out_valid_q, skid_valid_q;
	logic           push;

	assign adv  = !skid_valid_q;
	assign push = adv && v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || clip.ready) begin
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || clip.ready) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= res_c;
		end else if (push) begin
			skid_q <= res_c;
		end
	end

	assign clip.valid = out_valid_q;
	assign clip.data  = out_q;

endmodule

@@ rtl/lrc_checker.sv @@
// port-level checks of the clipper, bound to the top level
module lrc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input lrc_pkg::clip_t out_data
);

	logic [7:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// beats in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (in_acc && !out_acc)
			cnt_q <= cnt_q + 8'd1;
		else if (!in_acc && out_acc)
			cnt_q <= cnt_q - 8'd1;
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("clip beat changed while stalled");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.visible |-> out_data.clipped_start_x == '0
			&& out_data.clipped_start_y == '0 && out_data.clipped_end_x == '0
			&& out_data.clipped_end_y == '0)
		else $error("hidden segment with nonzero coordinates");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> cnt_q != '0)
		else $error("clip beat without a segment in flight");

	a_ready_recovers: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_ready) |-> in_ready)
		else $error("input held off although output was drained");

endmodule

bind line_rectangle_clipper lrc_checker u_lrc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(seg.valid),
	.in_ready(seg.ready),
	.out_valid(clip.valid),
	.out_ready(clip.ready),
	.out_data(clip.data)
);
